// ----- hw/rtl/osl_pkg.sv -----
package osl_pkg;

    localparam int LP_DEPTH   = 64;
    localparam int LP_VALUE_W = 32;
    localparam int LP_POS_W   = $clog2(LP_DEPTH);
    localparam int LP_CNT_W   = $clog2(LP_DEPTH + 1);
    localparam int LP_IN_POS_W = 7;
    localparam int LP_OP_W    = 4;
    localparam int LP_ST_W    = 2;
    localparam int LP_GRP_SZ  = 8;
    localparam int LP_GRP_W   = $clog2(LP_GRP_SZ);
    localparam int LP_NGRP    = LP_DEPTH / LP_GRP_SZ;
    localparam int LP_NGRP_W  = $clog2(LP_NGRP);

    localparam logic [LP_OP_W-1:0] OP_INSERT_AT    = 4'd0;
    localparam logic [LP_OP_W-1:0] OP_APPEND       = 4'd1;
    localparam logic [LP_OP_W-1:0] OP_FILL_EMPTY   = 4'd2;
    localparam logic [LP_OP_W-1:0] OP_REMOVE_AT    = 4'd3;
    localparam logic [LP_OP_W-1:0] OP_REMOVE_VALUE = 4'd4;
    localparam logic [LP_OP_W-1:0] OP_PUT_AT       = 4'd5;
    localparam logic [LP_OP_W-1:0] OP_FIND         = 4'd6;
    localparam logic [LP_OP_W-1:0] OP_CLEAR        = 4'd7;
    localparam logic [LP_OP_W-1:0] OP_READ_AT      = 4'd8;

    localparam logic [LP_ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [LP_ST_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [LP_ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [LP_ST_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        CA_HOLD,
        CA_INSERT,
        CA_REMOVE,
        CA_WRITE
    } t_cell_act;

    typedef struct packed {
        t_cell_act               action;
        logic [LP_POS_W-1:0]     pos;
        logic [LP_VALUE_W-1:0]   data;
        logic [LP_VALUE_W-1:0]   key;
    } t_cell_bus;

endpackage

// ----- hw/rtl/osl_cell.sv -----
module osl_cell
    import osl_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic                  i_clk,
    input  t_cell_bus             i_bus,
    input  logic                  i_live,
    input  logic [LP_VALUE_W-1:0] i_prev,
    input  logic [LP_VALUE_W-1:0] i_next,
    output logic [LP_VALUE_W-1:0] o_value,
    output logic                  o_match
);

    localparam logic [LP_POS_W-1:0] LP_IDX = LP_POS_W'(INDEX);

    logic [LP_VALUE_W-1:0] r_value;
    logic [LP_VALUE_W-1:0] n_value;
    logic                  r_match;

    always_comb begin
        n_value = r_value;
        unique case (i_bus.action)
            CA_INSERT: begin
                if (LP_IDX > i_bus.pos) begin
                    n_value = i_prev;
                end else if (LP_IDX == i_bus.pos) begin
                    n_value = i_bus.data;
                end
            end
            CA_REMOVE: begin
                if (LP_IDX >= i_bus.pos) begin
                    n_value = i_next;
                end
            end
            CA_WRITE: begin
                if (LP_IDX == i_bus.pos) begin
                    n_value = i_bus.data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_match <= i_live && (r_value == i_bus.key);
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

// ----- hw/rtl/osl_chain.sv -----
module osl_chain
    import osl_pkg::*;
(
    input  logic                  i_clk,
    input  t_cell_bus             i_bus,
    input  logic [LP_CNT_W-1:0]   i_count,
    input  logic [LP_POS_W-1:0]   i_rd_pos,
    output logic                  o_found,
    output logic [LP_POS_W-1:0]   o_where,
    output logic [LP_VALUE_W-1:0] o_rd_value
);

    logic [LP_VALUE_W-1:0] w_values [LP_DEPTH];
    logic [LP_DEPTH-1:0]   w_match;
    logic [LP_GRP_W-1:0]   w_grp_idx [LP_NGRP];
    logic [LP_NGRP-1:0]    r_grp_any;
    logic [LP_GRP_W-1:0]   r_grp_idx [LP_NGRP];
    logic [LP_VALUE_W-1:0] r_rd_value;

    for (genvar i = 0; i < LP_DEPTH; i++) begin : g_cell
        logic [LP_VALUE_W-1:0] w_prev;
        logic [LP_VALUE_W-1:0] w_next;

        if (i == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_prev
            assign w_prev = w_values[i-1];
        end
        if (i == LP_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_next
            assign w_next = w_values[i+1];
        end

        osl_cell #(
            .INDEX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_bus   (i_bus),
            .i_live  (LP_CNT_W'(i) < i_count),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_value (w_values[i]),
            .o_match (w_match[i])
        );
    end

    // First match within each group of eight cells, registered.
    always_comb begin
        for (int g = 0; g < LP_NGRP; g++) begin
            w_grp_idx[g] = '0;
            for (int k = LP_GRP_SZ - 1; k >= 0; k--) begin
                if (w_match[g*LP_GRP_SZ + k]) begin
                    w_grp_idx[g] = LP_GRP_W'(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < LP_NGRP; g++) begin
            r_grp_any[g] <= |w_match[g*LP_GRP_SZ +: LP_GRP_SZ];
            r_grp_idx[g] <= w_grp_idx[g];
        end
        r_rd_value <= w_values[i_rd_pos];
    end

    always_comb begin
        o_found = |r_grp_any;
        o_where = '0;
        for (int g = LP_NGRP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                o_where = {LP_NGRP_W'(g), r_grp_idx[g]};
            end
        end
    end

    assign o_rd_value = r_rd_value;

endmodule

// ----- hw/rtl/ordered_slot_list.sv -----
// Ordered slot list: an ordered list of up to 64 values of 32 bits with a live count.
// Input channel (i_in_valid / o_in_ready) carries one operation per beat: op, position
// and value. Output channel (o_out_valid / i_out_ready) returns one result beat for every
// operation: status, result position, value read and the entry count afterwards.
// The list is held in a row of 64 cells; inserts and removals shift every later entry
// by one place in the same update, and searches compare all cells in parallel.
// An accepted operation moves through S_MATCH, which registers the per-cell compares,
// S_LOCATE, which resolves the first match in groups of eight cells, and S_APPLY, in
// which the update is applied and the result registered.
// A new operation is accepted only in the idle state, so the block takes no new one
// before the result of the last one has been registered.
// If the receiver stalls while a result is waiting, the next operation is still accepted
// and worked through; its update and result are held back until the waiting beat is taken.
// Reset empties the list and drops any pending result; the cell contents are left as
// they were and are never read before being written.
module ordered_slot_list
    import osl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [LP_OP_W-1:0]     i_op,
    input  logic [LP_IN_POS_W-1:0] i_position,
    input  logic [LP_VALUE_W-1:0]  i_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [LP_ST_W-1:0]     o_status,
    output logic [LP_POS_W-1:0]    o_result_position,
    output logic [LP_VALUE_W-1:0]  o_result_value,
    output logic [LP_CNT_W-1:0]    o_entry_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_LOCATE,
        S_APPLY
    } t_state;

    t_state                  r_state;
    logic [LP_CNT_W-1:0]     r_count;
    logic [LP_OP_W-1:0]      r_op;
    logic [LP_IN_POS_W-1:0]  r_pos;
    logic [LP_VALUE_W-1:0]   r_value;
    logic                    r_out_valid;
    logic [LP_ST_W-1:0]      r_status;
    logic [LP_POS_W-1:0]     r_rpos;
    logic [LP_VALUE_W-1:0]   r_rval;
    logic [LP_CNT_W-1:0]     r_out_count;

    t_cell_bus               w_bus;
    logic                    w_found;
    logic [LP_POS_W-1:0]     w_where;
    logic [LP_VALUE_W-1:0]   w_rd_value;
    logic                    w_go;
    logic                    w_full;
    logic [LP_POS_W-1:0]     w_pos6;
    t_cell_act               w_act;
    logic [LP_POS_W-1:0]     w_apos;
    logic [LP_ST_W-1:0]      w_status;
    logic [LP_POS_W-1:0]     w_rpos;
    logic [LP_VALUE_W-1:0]   w_rval;
    logic [LP_CNT_W-1:0]     w_count;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_go       = !r_out_valid || i_out_ready;
    assign w_full     = (r_count == LP_CNT_W'(LP_DEPTH));
    assign w_pos6     = r_pos[LP_POS_W-1:0];

    always_comb begin
        w_act    = CA_HOLD;
        w_apos   = w_pos6;
        w_status = ST_OK;
        w_rpos   = '0;
        w_rval   = '0;
        w_count  = r_count;
        unique case (r_op)
            OP_INSERT_AT: begin
                if (LP_CNT_W'(r_pos) > r_count) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_act   = CA_INSERT;
                    w_rpos  = w_pos6;
                    w_count = r_count + 1'b1;
                end
            end
            OP_APPEND, OP_FILL_EMPTY: begin
                if (r_op == OP_FILL_EMPTY && w_found) begin
                    w_act  = CA_WRITE;
                    w_apos = w_where;
                    w_rpos = w_where;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_act   = CA_INSERT;
                    w_apos  = r_count[LP_POS_W-1:0];
                    w_rpos  = r_count[LP_POS_W-1:0];
                    w_count = r_count + 1'b1;
                end
            end
            OP_REMOVE_AT: begin
                if (LP_CNT_W'(r_pos) >= r_count || r_pos[LP_IN_POS_W-1]) begin
                    w_status = ST_RANGE;
                end else begin
                    w_act   = CA_REMOVE;
                    w_rpos  = w_pos6;
                    w_count = r_count - 1'b1;
                end
            end
            OP_REMOVE_VALUE: begin
                if (w_found) begin
                    w_act   = CA_REMOVE;
                    w_apos  = w_where;
                    w_rpos  = w_where;
                    w_count = r_count - 1'b1;
                end else begin
                    w_status = ST_NOTFOUND;
                end
            end
            OP_PUT_AT: begin
                if (LP_CNT_W'(r_pos) >= r_count || r_pos[LP_IN_POS_W-1]) begin
                    w_status = ST_RANGE;
                end else begin
                    w_act  = CA_WRITE;
                    w_rpos = w_pos6;
                end
            end
            OP_FIND: begin
                if (w_found) begin
                    w_rpos = w_where;
                end else begin
                    w_status = ST_NOTFOUND;
                end
            end
            OP_CLEAR: begin
                w_count = '0;
            end
            OP_READ_AT: begin
                if (LP_CNT_W'(r_pos) >= r_count || r_pos[LP_IN_POS_W-1]) begin
                    w_status = ST_RANGE;
                end else begin
                    w_rpos = w_pos6;
                    w_rval = w_rd_value;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_bus.action = (r_state == S_APPLY && w_go) ? w_act : CA_HOLD;
        w_bus.pos    = w_apos;
        w_bus.data   = r_value;
        w_bus.key    = (r_op == OP_FILL_EMPTY) ? '0 : r_value;
    end

    osl_chain u_chain (
        .i_clk      (i_clk),
        .i_bus      (w_bus),
        .i_count    (r_count),
        .i_rd_pos   (w_pos6),
        .o_found    (w_found),
        .o_where    (w_where),
        .o_rd_value (w_rd_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_state == S_APPLY && w_go) || (r_out_valid && !i_out_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_op;
                        r_pos   <= i_position;
                        r_value <= i_value;
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_state <= S_LOCATE;
                end
                S_LOCATE: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (w_go) begin
                        r_status    <= w_status;
                        r_rpos      <= w_rpos;
                        r_rval      <= w_rval;
                        r_out_count <= w_count;
                        r_count     <= w_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_result_position = r_rpos;
    assign o_result_value    = r_rval;
    assign o_entry_count     = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LP_CNT_W'(LP_DEPTH))
        else $error("entry count exceeds list depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again while an operation is in progress");

    a_error_clears_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
        (o_result_position == '0 && o_result_value == '0))
        else $error("error result carries a nonzero position or value");

    a_count_only_on_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_APPLY) |=> (r_count == $past(r_count)))
        else $error("entry count changed outside the update cycle");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import osl_pkg::*;

    localparam logic [LP_OP_W-1:0] OP_FIRST_UNUSED = 4'd9;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic [LP_OP_W-1:0]     op;
        logic [LP_IN_POS_W-1:0] pos;
        logic [LP_VALUE_W-1:0]  val;
    } t_request;

    typedef struct packed {
        logic [LP_ST_W-1:0]    st;
        logic [LP_POS_W-1:0]   pos;
        logic [LP_VALUE_W-1:0] val;
        logic [LP_CNT_W-1:0]   cnt;
    } t_outcome;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [LP_OP_W-1:0]     i_op = '0;
    logic [LP_IN_POS_W-1:0] i_position = '0;
    logic [LP_VALUE_W-1:0]  i_value = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [LP_ST_W-1:0]     o_status;
    logic [LP_POS_W-1:0]    o_result_position;
    logic [LP_VALUE_W-1:0]  o_result_value;
    logic [LP_CNT_W-1:0]    o_entry_count;

    ordered_slot_list i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_position        (i_position),
        .i_value           (i_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_result_position (o_result_position),
        .o_result_value    (o_result_value),
        .o_entry_count     (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the list as the block should hold it.
    logic [LP_VALUE_W-1:0] list_mem [LP_DEPTH];
    logic [LP_CNT_W-1:0]   list_len = '0;

    t_request request_backlog [$];
    t_outcome outcomes_due [$];
    int       queued_total = 0;
    int       accepted_total = 0;
    int       fault_count = 0;
    int       quiet_cycles = 0;
    logic     in_beat = 1'b0;
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    int       hold_requests = 0;
    int       hold_served = 0;
    int       hold_left = 0;
    t_request next_request;

    int       est_len = 0;
    int       len_goal = 0;
    int       goal_choices [5] = '{0, 3, 20, 64, 64};
    int       grow_cut [9] = '{25, 45, 55, 60, 63, 73, 83, 96, 96};
    int       shrink_cut [9] = '{10, 15, 20, 45, 60, 70, 80, 94, 96};
    logic [LP_OP_W-1:0] op_order [9] = '{OP_INSERT_AT, OP_APPEND, OP_FILL_EMPTY, OP_REMOVE_AT,
                                         OP_REMOVE_VALUE, OP_PUT_AT, OP_FIND, OP_READ_AT,
                                         OP_CLEAR};
    logic [LP_VALUE_W-1:0] value_pool [8];
    logic [LP_VALUE_W-1:0] extreme_values [3] = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};

    function automatic int first_index_of(logic [LP_VALUE_W-1:0] v);
        for (int i = 0; i < list_len; i++) begin
            if (list_mem[i] == v) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [LP_ST_W-1:0] shift_in(int p, logic [LP_VALUE_W-1:0] v);
        if (p > list_len) begin
            return ST_RANGE;
        end
        if (list_len >= LP_DEPTH) begin
            return ST_FULL;
        end
        for (int i = list_len; i > p; i--) begin
            list_mem[i] = list_mem[i-1];
        end
        list_mem[p] = v;
        list_len++;
        return ST_OK;
    endfunction

    function automatic logic [LP_ST_W-1:0] shift_out(int p);
        if (p >= list_len) begin
            return ST_RANGE;
        end
        for (int i = p; i + 1 < list_len; i++) begin
            list_mem[i] = list_mem[i+1];
        end
        list_len--;
        return ST_OK;
    endfunction

    function automatic t_outcome list_apply(t_request rq);
        t_outcome res;
        int       hit;
        res = '0;
        hit = -1;
        case (rq.op)
            OP_INSERT_AT: begin
                res.st  = shift_in(rq.pos, rq.val);
                res.pos = rq.pos[LP_POS_W-1:0];
            end
            OP_APPEND: begin
                res.pos = list_len[LP_POS_W-1:0];
                res.st  = shift_in(list_len, rq.val);
            end
            OP_FILL_EMPTY: begin
                hit = first_index_of('0);
                if (hit >= 0) begin
                    list_mem[hit] = rq.val;
                    res.pos = hit[LP_POS_W-1:0];
                end else begin
                    res.pos = list_len[LP_POS_W-1:0];
                    res.st  = shift_in(list_len, rq.val);
                end
            end
            OP_REMOVE_AT: begin
                res.st  = shift_out(rq.pos);
                res.pos = rq.pos[LP_POS_W-1:0];
            end
            OP_REMOVE_VALUE: begin
                hit = first_index_of(rq.val);
                if (hit < 0) begin
                    res.st = ST_NOTFOUND;
                end else begin
                    res.st  = shift_out(hit);
                    res.pos = hit[LP_POS_W-1:0];
                end
            end
            OP_PUT_AT: begin
                if (rq.pos >= list_len) begin
                    res.st = ST_RANGE;
                end else begin
                    list_mem[rq.pos] = rq.val;
                    res.pos = rq.pos[LP_POS_W-1:0];
                end
            end
            OP_FIND: begin
                hit = first_index_of(rq.val);
                if (hit < 0) begin
                    res.st = ST_NOTFOUND;
                end else begin
                    res.pos = hit[LP_POS_W-1:0];
                end
            end
            OP_CLEAR: begin
                list_len = '0;
            end
            OP_READ_AT: begin
                if (rq.pos >= list_len) begin
                    res.st = ST_RANGE;
                end else begin
                    res.pos = rq.pos[LP_POS_W-1:0];
                    res.val = list_mem[rq.pos];
                end
            end
            default: begin
            end
        endcase
        if (res.st != ST_OK) begin
            res.pos = '0;
            res.val = '0;
        end
        res.cnt = list_len;
        return res;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            fault_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_beat <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            in_beat <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (outcomes_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected, status %0d position %0d",
                             $time, o_status, o_result_position);
                    fault_count++;
                end else begin
                    t_outcome want;
                    want = outcomes_due.pop_front();
                    check_field("status", want.st, o_status);
                    check_field("result_position", want.pos, o_result_position);
                    check_field("result_value", want.val, o_result_value);
                    check_field("entry_count", want.cnt, o_entry_count);
                end
            end
            if (i_in_valid && o_in_ready) begin
                outcomes_due.push_back(list_apply({i_op, i_position, i_value}));
                accepted_total++;
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_beat) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_request = request_backlog.pop_front();
                i_in_valid <= 1'b1;
                i_op       <= next_request.op;
                i_position <= next_request.pos;
                i_value    <= next_request.val;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic queue_item(logic [LP_OP_W-1:0] op, logic [LP_IN_POS_W-1:0] pos,
                              logic [LP_VALUE_W-1:0] val);
        request_backlog.push_back({op, pos, val});
        queued_total++;
    endtask

    function automatic logic [LP_VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 40) begin
            return value_pool[$urandom_range(7)];
        end
        if (r < 55) begin
            return '0;
        end
        if (r < 65) begin
            return extreme_values[$urandom_range(2)];
        end
        return $urandom;
    endfunction

    function automatic logic [LP_IN_POS_W-1:0] pick_position(int lim);
        int r;
        r = $urandom_range(9);
        if (r < 7 && lim > 0) begin
            return $urandom_range(lim - 1);
        end
        if (r < 9) begin
            return lim + $urandom_range(1);
        end
        return $urandom_range(127);
    endfunction

    task automatic queue_random(int n);
        int                     r;
        logic [LP_OP_W-1:0]     op;
        logic [LP_IN_POS_W-1:0] pos;
        logic [LP_VALUE_W-1:0]  val;
        for (int i = 0; i < n; i++) begin
            if (i % 80 == 0) begin
                len_goal = goal_choices[$urandom_range(4)];
            end
            r = $urandom_range(99);
            op = OP_FIRST_UNUSED + $urandom_range(6);
            for (int k = 0; k < 9; k++) begin
                if (r < (est_len < len_goal ? grow_cut[k] : shrink_cut[k])) begin
                    op = op_order[k];
                    break;
                end
            end
            val = pick_value();
            case (op)
                OP_INSERT_AT: pos = pick_position(est_len + 1);
                OP_REMOVE_AT, OP_PUT_AT, OP_READ_AT: pos = pick_position(est_len);
                default: pos = $urandom_range(127);
            endcase
            case (op)
                OP_INSERT_AT: begin
                    if (pos <= est_len && est_len < LP_DEPTH) begin
                        est_len++;
                    end
                end
                OP_APPEND, OP_FILL_EMPTY: begin
                    if (est_len < LP_DEPTH) begin
                        est_len++;
                    end
                end
                OP_REMOVE_AT: begin
                    if (pos < est_len) begin
                        est_len--;
                    end
                end
                OP_REMOVE_VALUE: begin
                    if (est_len > 0 && val != 0) begin
                        est_len--;
                    end
                end
                OP_CLEAR: est_len = 0;
                default: begin
                end
            endcase
            queue_item(op, pos, val);
        end
    endtask

    task automatic wait_drained();
        while (accepted_total != queued_total || outcomes_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        queue_random(n);
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < 8; i++) begin
            value_pool[i] = $urandom;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list, then a few entries exercising every operation and its range and not-found errors.
        queue_item(OP_READ_AT, 0, 32'h0);
        queue_item(OP_REMOVE_AT, 0, 32'h0);
        queue_item(OP_FIND, 0, 32'h5);
        queue_item(OP_REMOVE_VALUE, 0, 32'h5);
        queue_item(OP_INSERT_AT, 1, 32'h7);
        queue_item(OP_INSERT_AT, 0, 32'hFFFF_FFFF);
        queue_item(OP_APPEND, 0, 32'h0);
        queue_item(OP_APPEND, 127, 32'h1);
        queue_item(OP_INSERT_AT, 1, 32'h8000_0000);
        queue_item(OP_FILL_EMPTY, 0, 32'h1234_5678);
        queue_item(OP_FILL_EMPTY, 0, 32'hA5A5_A5A5);
        queue_item(OP_PUT_AT, 0, 32'h0);
        queue_item(OP_PUT_AT, 127, 32'hDEAD_BEEF);
        queue_item(OP_READ_AT, 2, 32'h0);
        queue_item(OP_READ_AT, 64, 32'h0);
        queue_item(OP_FIND, 0, 32'h8000_0000);
        queue_item(OP_REMOVE_VALUE, 0, 32'h1);
        queue_item(OP_REMOVE_AT, 0, 32'h0);
        queue_item(OP_INSERT_AT, 127, 32'h3);
        queue_item(OP_FIRST_UNUSED, 5, 32'h9);
        queue_item(4'hF, 127, 32'hFFFF_FFFF);
        queue_item(OP_CLEAR, 0, 32'h0);
        queue_item(OP_READ_AT, 0, 32'h0);

        // Fill the list completely, hit it with every growing operation, then put, read, remove and clear.
        for (int i = 0; i < LP_DEPTH; i++) begin
            queue_item(OP_APPEND, 0, $urandom | 32'h1);
        end
        queue_item(OP_INSERT_AT, 65, 32'h3);
        queue_item(OP_INSERT_AT, 64, 32'h3);
        queue_item(OP_INSERT_AT, 0, 32'h3);
        queue_item(OP_APPEND, 0, 32'h3);
        queue_item(OP_FILL_EMPTY, 0, 32'h3);
        queue_item(OP_PUT_AT, 63, 32'h0);
        queue_item(OP_READ_AT, 63, 32'h0);
        queue_item(OP_FILL_EMPTY, 0, 32'h4);
        queue_item(OP_REMOVE_AT, 63, 32'h0);
        queue_item(OP_READ_AT, 63, 32'h0);
        queue_item(OP_CLEAR, 0, 32'h0);
        est_len = 0;
        wait_drained();

        run_phase(330, 0, 0);
        run_phase(300, 87, 0);
        run_phase(300, 0, 87);
        run_phase(300, 31, 31);

        // The receiver holds off long enough for the block to back up its input.
        send_idle_pct = 0;
        stall_pct = 0;
        @(posedge i_clk);
        hold_requests++;
        queue_random(80);
        wait_drained();

        run_phase(200, 31, 31);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/osl_pkg.sv
hw/rtl/osl_cell.sv
hw/rtl/osl_chain.sv
hw/rtl/ordered_slot_list.sv
sim/tb_top.sv
